[hw/rtl/cha_pkg.sv]
// Shared constants and stage payload type for the compass heading datapath.
package cha_pkg;

    localparam int SAMPLE_WIDTH      = 16;
    localparam int HEADING_FRAC_BITS = 6;

    localparam int QUARTER_TURN = 90 << HEADING_FRAC_BITS;
    localparam int FULL_TURN    = 4 * QUARTER_TURN;

    // quotient never exceeds a quarter turn
    localparam int QUO_W  = $clog2(QUARTER_TURN + 1);
    localparam int MAG_W  = SAMPLE_WIDTH;         // |sample| up to 2^(SW-1)
    localparam int DIV_W  = SAMPLE_WIDTH + 1;     // |x| + |y|
    localparam int PROD_W = MAG_W + QUO_W;
    localparam int ANG_W  = QUO_W + 2;

    localparam int HEADING_W = 15;
    localparam int IN_TDATA_W  = 2 * SAMPLE_WIDTH;
    localparam int OUT_TDATA_W = ((HEADING_W + 7) / 8) * 8;

    // one slot of the divider chain
    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] dvd_lo;
        logic [QUO_W-1:0] quo;
        logic [DIV_W-1:0] dvs;
        logic             x_neg;
        logic             y_neg;
        logic             zero;
    } div_slot_t;

endpackage

[hw/rtl/cha_prep.sv]
// Front stages: magnitudes and divisor, then scaled dividend for the divider.
module cha_prep (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic [cha_pkg::IN_TDATA_W-1:0]  in_data,
    output cha_pkg::div_slot_t              slot_out
);

    logic signed [cha_pkg::SAMPLE_WIDTH-1:0] mag_x;
    logic signed [cha_pkg::SAMPLE_WIDTH-1:0] mag_y;
    logic [cha_pkg::MAG_W-1:0] abs_x;
    logic [cha_pkg::MAG_W-1:0] abs_y;

    logic                      s1_valid_reg;
    logic [cha_pkg::MAG_W-1:0] s1_num_reg;
    logic [cha_pkg::DIV_W-1:0] s1_dvs_reg;
    logic                      s1_x_neg_reg;
    logic                      s1_y_neg_reg;
    logic                      s1_zero_reg;

    logic [cha_pkg::PROD_W-1:0] prod;
    cha_pkg::div_slot_t         s2_next;
    cha_pkg::div_slot_t         s2_reg;

    assign mag_x = in_data[cha_pkg::SAMPLE_WIDTH-1:0];
    assign mag_y = in_data[2*cha_pkg::SAMPLE_WIDTH-1:cha_pkg::SAMPLE_WIDTH];
    assign abs_x = mag_x[cha_pkg::SAMPLE_WIDTH-1] ? (~mag_x + 1'b1) : mag_x;
    assign abs_y = mag_y[cha_pkg::SAMPLE_WIDTH-1] ? (~mag_y + 1'b1) : mag_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            // numerator is |y| in the right half-plane, |x| in the left
            s1_num_reg   <= mag_x[cha_pkg::SAMPLE_WIDTH-1] ? abs_x : abs_y;
            s1_dvs_reg   <= {1'b0, abs_x} + {1'b0, abs_y};
            s1_x_neg_reg <= mag_x[cha_pkg::SAMPLE_WIDTH-1];
            s1_y_neg_reg <= mag_y[cha_pkg::SAMPLE_WIDTH-1];
            s1_zero_reg  <= (mag_x == '0) && (mag_y == '0);
        end
    end

    assign prod = cha_pkg::QUO_W'(cha_pkg::QUARTER_TURN) * s1_num_reg;

    always_comb begin
        s2_next.valid  = s1_valid_reg;
        // quotient fits QUO_W bits, so the high part is already below the divisor
        s2_next.rem    = cha_pkg::DIV_W'(prod[cha_pkg::PROD_W-1:cha_pkg::QUO_W]);
        s2_next.dvd_lo = prod[cha_pkg::QUO_W-1:0];
        s2_next.quo    = '0;
        s2_next.dvs    = s1_dvs_reg;
        s2_next.x_neg  = s1_x_neg_reg;
        s2_next.y_neg  = s1_y_neg_reg;
        s2_next.zero   = s1_zero_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg.valid <= 1'b0;
        end else if (ce) begin
            s2_reg.valid <= s2_next.valid;
        end
        if (ce) begin
            s2_reg.rem    <= s2_next.rem;
            s2_reg.dvd_lo <= s2_next.dvd_lo;
            s2_reg.quo    <= s2_next.quo;
            s2_reg.dvs    <= s2_next.dvs;
            s2_reg.x_neg  <= s2_next.x_neg;
            s2_reg.y_neg  <= s2_next.y_neg;
            s2_reg.zero   <= s2_next.zero;
        end
    end

    assign slot_out = s2_reg;

endmodule

[hw/rtl/cha_div_cell.sv]
// One restoring-division cell: develops one quotient bit and hands the slot on.
module cha_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ce,
    input  cha_pkg::div_slot_t slot_in,
    output cha_pkg::div_slot_t slot_out
);

    logic [cha_pkg::DIV_W:0] trial;
    logic                    fits;
    cha_pkg::div_slot_t      slot_next;
    cha_pkg::div_slot_t      slot_reg;

    // bring down the next dividend bit
    assign trial = {slot_in.rem, slot_in.dvd_lo[cha_pkg::QUO_W-1]};
    assign fits  = trial >= {1'b0, slot_in.dvs};

    always_comb begin
        slot_next        = slot_in;
        slot_next.rem    = fits ? cha_pkg::DIV_W'(trial - {1'b0, slot_in.dvs})
                                : trial[cha_pkg::DIV_W-1:0];
        slot_next.dvd_lo = {slot_in.dvd_lo[cha_pkg::QUO_W-2:0], 1'b0};
        slot_next.quo    = {slot_in.quo[cha_pkg::QUO_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else if (ce) begin
            slot_reg.valid <= slot_next.valid;
        end
        if (ce) begin
            slot_reg.rem    <= slot_next.rem;
            slot_reg.dvd_lo <= slot_next.dvd_lo;
            slot_reg.quo    <= slot_next.quo;
            slot_reg.dvs    <= slot_next.dvs;
            slot_reg.x_neg  <= slot_next.x_neg;
            slot_reg.y_neg  <= slot_next.y_neg;
            slot_reg.zero   <= slot_next.zero;
        end
    end

    assign slot_out = slot_reg;

endmodule

[hw/rtl/compass_heading_atan2.sv]
// Top level: compass heading from a magnetometer X,Y pair by linear arctangent.
//
// Takes one signed X,Y sample pair per item and returns the heading in degrees
// times 64 (0 to 23039), counted from +X towards +Y. Within each quadrant the
// angle is linear in |y|/(|x|+|y|), truncated; a zero vector reads 0. One item
// is accepted every cycle while the output is not stalled; each passes through two
// front stages (magnitudes, then the scaling multiply), a row of 13 divider
// cells producing one quotient bit each, and the output register. The whole
// pipeline advances together and holds while a result waits on m_tready.
module compass_heading_atan2 (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cha_pkg::IN_TDATA_W-1:0]   s_tdata,  // [15:0] mag_x, [31:16] mag_y
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cha_pkg::OUT_TDATA_W-1:0]  m_tdata   // [14:0] heading_q6, [15] zero pad
);

    logic               ce;
    cha_pkg::div_slot_t chain [0:cha_pkg::QUO_W];

    logic [cha_pkg::ANG_W-1:0] half_ang;
    logic [cha_pkg::ANG_W-1:0] angle_next;
    logic                      out_valid_reg;
    logic [cha_pkg::ANG_W-1:0] angle_reg;

    // advance when the output register is empty or being drained
    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    cha_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .slot_out (chain[0])
    );

    for (genvar i = 0; i < cha_pkg::QUO_W; i++) begin : g_cell
        cha_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .slot_in  (chain[i]),
            .slot_out (chain[i+1])
        );
    end

    always_comb begin
        half_ang = chain[cha_pkg::QUO_W].x_neg
                 ? cha_pkg::ANG_W'(cha_pkg::QUARTER_TURN)
                   + cha_pkg::ANG_W'(chain[cha_pkg::QUO_W].quo)
                 : cha_pkg::ANG_W'(chain[cha_pkg::QUO_W].quo);
        if (chain[cha_pkg::QUO_W].zero) begin
            angle_next = '0;
        end else if (chain[cha_pkg::QUO_W].y_neg && half_ang != '0) begin
            angle_next = cha_pkg::ANG_W'(cha_pkg::FULL_TURN) - half_ang;
        end else begin
            // lower half-plane with zero angle wraps to 0 instead of a full turn
            angle_next = half_ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= chain[cha_pkg::QUO_W].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            angle_reg <= angle_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cha_pkg::OUT_TDATA_W'(cha_pkg::HEADING_W'(angle_reg));

    a_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (angle_reg < cha_pkg::ANG_W'(cha_pkg::FULL_TURN)))
        else $error("heading out of range");

    a_rem : assert property (@(posedge aclk) disable iff (!aresetn)
        (chain[cha_pkg::QUO_W].valid && !chain[cha_pkg::QUO_W].zero)
            |-> (chain[cha_pkg::QUO_W].rem < chain[cha_pkg::QUO_W].dvs))
        else $error("divider remainder not below divisor");

    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline stalled");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the compass heading block: random and corner vectors, stalls.
module testbench;

    localparam longint QUARTER     = longint'(cha_pkg::QUARTER_TURN);
    localparam longint FULL_CIRCLE = longint'(cha_pkg::FULL_TURN);
    localparam int PIPE_LATENCY    = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PER_PHASE = 330;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [cha_pkg::IN_TDATA_W-1:0]   s_tdata  = '0;   // [15:0] mag_x, [31:16] mag_y
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [cha_pkg::OUT_TDATA_W-1:0]  m_tdata;         // [14:0] heading_q6, [15] zero pad

    logic [cha_pkg::IN_TDATA_W-1:0] pending_vectors[$];
    logic [cha_pkg::HEADING_W-1:0]  expected_headings[$];

    int send_idle_pct = 34;
    int recv_idle_pct = 52;
    logic hold_armed  = 1'b0;
    int vectors_sent  = 0;
    int headings_seen = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    compass_heading_atan2 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Linear arctangent per quadrant, in degrees * 64.
    function automatic logic [cha_pkg::HEADING_W-1:0] heading_for(logic signed [15:0] mx,
                                                                  logic signed [15:0] my);
        longint sx, sy, mag_y, angle;
        sx = longint'(mx);
        sy = longint'(my);
        if (sx == 0 && sy == 0)
            return '0;
        mag_y = (sy < 0) ? -sy : sy;
        if (sx >= 0)
            angle = (QUARTER * mag_y) / (sx + mag_y);
        else
            angle = QUARTER + (QUARTER * -sx) / (mag_y - sx);
        if (sy < 0) begin
            angle = FULL_CIRCLE - angle;
            // wrap a full turn back to zero
            if (angle >= FULL_CIRCLE)
                angle = 0;
        end
        return angle[cha_pkg::HEADING_W-1:0];
    endfunction

    function automatic logic signed [15:0] corner_sample(int k);
        case (k)
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic logic [cha_pkg::IN_TDATA_W-1:0] random_vector();
        logic signed [15:0] mx, my;
        mx = 16'($urandom);
        my = 16'($urandom);
        case ($urandom_range(0, 7))
            3: begin
                mx = 16'(int'($urandom_range(0, 16)) - 8);
                my = 16'(int'($urandom_range(0, 16)) - 8);
            end
            4: begin
                if ($urandom_range(0, 1)) mx = '0;
                else my = '0;
            end
            5: begin
                // tiny y against large positive x: angle truncates to zero
                mx = 16'sh6000 + 16'($urandom_range(0, 16'h1fff));
                my = 16'(int'($urandom_range(0, 6)) - 3);
            end
            6: begin
                mx = corner_sample(int'($urandom_range(0, 5)));
                my = corner_sample(int'($urandom_range(0, 5)));
            end
            7: my = 16'(int'($urandom_range(0, 128)) - 64);
            default: ;
        endcase
        return {my, mx};
    endfunction

    task automatic queue_vector(int mx, int my);
        logic signed [15:0] x16, y16;
        x16 = 16'(mx);
        y16 = 16'(my);
        pending_vectors.push_back({y16, x16});
    endtask

    task automatic drain_all();
        while (pending_vectors.size() != 0 || s_tvalid || expected_headings.size() != 0)
            @(negedge aclk);
    endtask

    // Driver: present queued items, idling at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_headings.push_back(heading_for(s_tdata[15:0], s_tdata[31:16]));
                vectors_sent++;
            end
            if (pending_vectors.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata  <= pending_vectors.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each result, then pick the next ready level.
    always @(posedge aclk) begin
        logic [cha_pkg::HEADING_W-1:0] want;
        int hold_left;
        bit hold_done;
        if (m_tvalid && m_tready) begin
            headings_seen++;
            if (expected_headings.size() == 0) begin
                $display("%0t: unexpected item, actual heading %0d", $time, m_tdata[14:0]);
                mismatches++;
            end else begin
                want = expected_headings.pop_front();
                if (m_tdata[14:0] !== want) begin
                    $display("%0t: heading mismatch, expected %0d actual %0d",
                             $time, want, m_tdata[14:0]);
                    mismatches++;
                end
            end
        end
        if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d headings pending",
                     cycle_count, expected_headings.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // zero vector, axes, extremes, full-turn wrap, negative x axis
        queue_vector(0, 0);
        queue_vector(32767, 0);
        queue_vector(-32768, 0);
        queue_vector(-1, 0);
        queue_vector(0, 32767);
        queue_vector(0, -32768);
        queue_vector(0, 1);
        queue_vector(0, -1);
        queue_vector(32767, 32767);
        queue_vector(-32768, -32768);
        queue_vector(-32768, 32767);
        queue_vector(32767, -32768);
        queue_vector(32767, -1);
        queue_vector(32767, 1);
        queue_vector(-32768, -1);
        queue_vector(-1, -32768);
        queue_vector(1, 1);
        queue_vector(1, -1);
        queue_vector(-1, 1);
        queue_vector(-1, -1);
        queue_vector(100, -2);
        repeat (RANDOM_PER_PHASE) pending_vectors.push_back(random_vector());
        drain_all();

        @(negedge aclk);
        send_idle_pct = 52;
        recv_idle_pct = 34;
        repeat (RANDOM_PER_PHASE) pending_vectors.push_back(random_vector());
        drain_all();

        // no idling; hold the output long enough to back up the pipeline
        @(negedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed    = 1'b1;
        repeat (RANDOM_PER_PHASE + 20) pending_vectors.push_back(random_vector());
        drain_all();

        repeat (PIPE_LATENCY + 4) @(posedge aclk);
        if (expected_headings.size() != 0) begin
            $display("%0t: %0d expected headings never arrived", $time,
                     expected_headings.size());
            mismatches++;
        end
        $display("Sent %0d vectors (corners, axes, wrap cases, random) and checked %0d headings",
                 vectors_sent, headings_seen);
        $display("under three idle patterns and one %0d-cycle output hold-off; %0d mismatches",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
